### src/cptt_pkg.sv
package cptt_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int CH_W             = 2;
	localparam int COUNT_W          = 16;
	localparam int NORM_W           = 9;
	localparam int REM_W            = COUNT_W + 1;
	localparam int QUARTER_SHIFT    = 2;
	localparam int DIV_STEPS        = NORM_W;
	localparam int STEP_W           = $clog2(DIV_STEPS);

	localparam logic [NORM_W-1:0] NORM_MAX  = NORM_W'(256);
	localparam logic              MODE_MEAS = 1'b0;
	localparam logic              MODE_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} cptt_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cptt_cmd_t;

	typedef struct packed {
		logic no_peak;
	} cptt_sts_t;

endpackage

### src/capsense_peak_track_touch_unit.sv
// channel  | direction | handshake        | fields
// command  | in        | start, busy      | mode, channel, count
// result   | out       | done (1 cycle)   | raw_count, peak_count, normalized, pressed, no_peak
//
// A transaction is taken at a clock edge with start high and busy low.
// Result strobe done follows acceptance after the 9 divide steps of the serial divider
// and the finish state, from which done is registered; when the peak is zero no divide steps run.
// busy drops in the cycle done is high, so the next command may go in then.
// Reset clears both per-channel stores and the controller.
// Results are held until the next done; the receiver cannot stall.
module capsense_peak_track_touch_unit #(
	parameter int NUM_CHANNELS = cptt_pkg::NUM_CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [cptt_pkg::CH_W-1:0]    channel,
	input  logic [cptt_pkg::COUNT_W-1:0] count,
	output logic                         done,
	output logic [cptt_pkg::COUNT_W-1:0] raw_count,
	output logic [cptt_pkg::COUNT_W-1:0] peak_count,
	output logic [cptt_pkg::NORM_W-1:0]  normalized,
	output logic                         pressed,
	output logic                         no_peak
);

	cptt_pkg::cptt_cmd_t cmd;
	cptt_pkg::cptt_sts_t sts;

	cptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cptt_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.channel    (channel),
		.count      (count),
		.raw_count  (raw_count),
		.peak_count (peak_count),
		.normalized (normalized),
		.pressed    (pressed),
		.no_peak    (no_peak)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done outside end of transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((peak_count >= raw_count) && (normalized <= cptt_pkg::NORM_MAX)
			&& (!no_peak || ((normalized == '0) && !pressed && (peak_count == '0)))))
		else $error("inconsistent result");

endmodule

### src/cptt_ctrl.sv
module cptt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cptt_pkg::cptt_sts_t sts,
	output cptt_pkg::cptt_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	cptt_pkg::cptt_state_t            state_q, state_d;
	logic [cptt_pkg::STEP_W-1:0]      step_q, step_d;
	logic                             done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cptt_pkg::ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		done_d     = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			cptt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = cptt_pkg::ST_DIV;
				end
			end
			cptt_pkg::ST_DIV: begin
				if (sts.no_peak) begin
					state_d = cptt_pkg::ST_FIN;
				end else begin
					cmd.step = 1'b1;
					step_d   = step_q + 1'b1;
					if (step_q == cptt_pkg::STEP_W'(cptt_pkg::DIV_STEPS - 1)) begin
						state_d = cptt_pkg::ST_FIN;
					end
				end
			end
			cptt_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				done_d     = 1'b1;
				state_d    = cptt_pkg::ST_IDLE;
			end
			default: begin
				state_d = cptt_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != cptt_pkg::ST_IDLE);
	assign done = done_q;

endmodule

### src/cptt_dp.sv
module cptt_dp #(
	parameter int NUM_CHANNELS = cptt_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cptt_pkg::cptt_cmd_t                 cmd,
	output cptt_pkg::cptt_sts_t                 sts,
	input  logic                                mode,
	input  logic [cptt_pkg::CH_W-1:0]           channel,
	input  logic [cptt_pkg::COUNT_W-1:0]        count,
	output logic [cptt_pkg::COUNT_W-1:0]        raw_count,
	output logic [cptt_pkg::COUNT_W-1:0]        peak_count,
	output logic [cptt_pkg::NORM_W-1:0]         normalized,
	output logic                                pressed,
	output logic                                no_peak
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [cptt_pkg::COUNT_W-1:0] latest_q [NUM_CHANNELS];
	logic [cptt_pkg::COUNT_W-1:0] peaks_q  [NUM_CHANNELS];

	logic [IDX_W-1:0]             idx;
	logic                         in_range;
	logic                         wr_en;
	logic [cptt_pkg::COUNT_W-1:0] cur_raw, cur_peak, new_raw, new_peak, thresh;

	logic [cptt_pkg::COUNT_W-1:0] raw_q, peak_q;
	logic [cptt_pkg::REM_W-1:0]   rem_q, rem_sub, rem_keep;
	logic [cptt_pkg::NORM_W-1:0]  quo_q;
	logic                         pressed_q, nopeak_q, ge;

	assign idx      = IDX_W'(channel);
	assign in_range = (32'(channel) < NUM_CHANNELS);
	assign wr_en    = cmd.load && in_range && (mode == cptt_pkg::MODE_MEAS);

	always_comb begin
		cur_raw  = in_range ? latest_q[idx] : '0;
		cur_peak = in_range ? peaks_q[idx]  : '0;
		new_raw  = cur_raw;
		new_peak = cur_peak;
		if (in_range && (mode == cptt_pkg::MODE_MEAS)) begin
			new_raw  = count;
			new_peak = (count > cur_peak) ? count : cur_peak;
		end
		thresh = new_peak - (new_peak >> cptt_pkg::QUARTER_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				latest_q[i] <= '0;
				peaks_q[i]  <= '0;
			end
		end else if (wr_en) begin
			latest_q[idx] <= new_raw;
			peaks_q[idx]  <= new_peak;
		end
	end

	// restoring divide: (raw << 8) / peak, one quotient bit per step
	assign ge       = (rem_q >= {1'b0, peak_q});
	assign rem_sub  = rem_q - {1'b0, peak_q};
	assign rem_keep = ge ? rem_sub : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q     <= new_raw;
			peak_q    <= new_peak;
			rem_q     <= {1'b0, new_raw};
			quo_q     <= '0;
			pressed_q <= (new_raw < thresh);
			nopeak_q  <= (new_peak == '0);
		end else if (cmd.step) begin
			rem_q <= {rem_keep[cptt_pkg::REM_W-2:0], 1'b0};
			quo_q <= {quo_q[cptt_pkg::NORM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			raw_count  <= raw_q;
			peak_count <= peak_q;
			no_peak    <= nopeak_q;
			pressed    <= nopeak_q ? 1'b0 : pressed_q;
			if (nopeak_q) begin
				normalized <= '0;
			end else begin
				normalized <= (quo_q > cptt_pkg::NORM_MAX) ? cptt_pkg::NORM_MAX : quo_q;
			end
		end
	end

	assign sts.no_peak = nopeak_q;

endmodule

### tb/tb_capsense_peak_track_touch_unit.sv
`timescale 1ns / 1ps

module tb_capsense_peak_track_touch_unit;

	localparam int NUM_CH = cptt_pkg::NUM_CHANNELS_DEF;

	typedef struct {
		logic                          mode;
		logic [cptt_pkg::CH_W-1:0]     channel;
		logic [cptt_pkg::COUNT_W-1:0]  count;
		bit                            drain;
	} touch_cmd_t;

	typedef struct packed {
		logic [cptt_pkg::COUNT_W-1:0] raw;
		logic [cptt_pkg::COUNT_W-1:0] peak;
		logic [cptt_pkg::NORM_W-1:0]  norm;
		logic                         pressed;
		logic                         no_peak;
	} touch_report_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic                         mode = cptt_pkg::MODE_MEAS;
	logic [cptt_pkg::CH_W-1:0]    channel = '0;
	logic [cptt_pkg::COUNT_W-1:0] count = '0;
	logic                         done;
	logic [cptt_pkg::COUNT_W-1:0] raw_count;
	logic [cptt_pkg::COUNT_W-1:0] peak_count;
	logic [cptt_pkg::NORM_W-1:0]  normalized;
	logic                         pressed;
	logic                         no_peak;

	touch_cmd_t    touch_cmds_pending[$];
	touch_report_t touch_reports_due[$];

	// predictor state
	logic [cptt_pkg::COUNT_W-1:0] ch_latest [NUM_CH];
	logic [cptt_pkg::COUNT_W-1:0] ch_peak   [NUM_CH];
	// peak mirror used only to shape stimulus
	logic [cptt_pkg::COUNT_W-1:0] plan_peak [NUM_CH];

	int send_idle_pct = 31;
	int mismatch_cnt  = 0;

	capsense_peak_track_touch_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.channel    (channel),
		.count      (count),
		.done       (done),
		.raw_count  (raw_count),
		.peak_count (peak_count),
		.normalized (normalized),
		.pressed    (pressed),
		.no_peak    (no_peak)
	);

	always #6 clk = ~clk;

	task automatic track_touch(input logic m, input logic [cptt_pkg::CH_W-1:0] ch,
			input logic [cptt_pkg::COUNT_W-1:0] cnt);
		touch_report_t r;
		logic [31:0]   q;
		r = '0;
		r.no_peak = 1'b1;
		if (ch < NUM_CH) begin
			if (m == cptt_pkg::MODE_MEAS) begin
				ch_latest[ch] = cnt;
				if (cnt > ch_peak[ch])
					ch_peak[ch] = cnt;
			end
			r.raw  = ch_latest[ch];
			r.peak = ch_peak[ch];
			if (r.peak != '0) begin
				q = (32'(r.raw) << 8) / 32'(r.peak);
				r.norm    = (q > 32'(cptt_pkg::NORM_MAX)) ? cptt_pkg::NORM_MAX
					: q[cptt_pkg::NORM_W-1:0];
				r.pressed = r.raw < (r.peak - (r.peak >> cptt_pkg::QUARTER_SHIFT));
				r.no_peak = 1'b0;
			end
		end
		touch_reports_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_cmds
		touch_cmd_t nxt;
		if (!arst_n) begin
			start   <= 1'b0;
			mode    <= cptt_pkg::MODE_MEAS;
			channel <= '0;
			count   <= '0;
		end else begin
			if (start && !busy)
				track_touch(mode, channel, count);
			if (!start || !busy) begin
				if (touch_cmds_pending.size() != 0 &&
						!(touch_cmds_pending[0].drain && touch_reports_due.size() != 0) &&
						$urandom_range(99) >= send_idle_pct) begin
					nxt = touch_cmds_pending.pop_front();
					start   <= 1'b1;
					mode    <= nxt.mode;
					channel <= nxt.channel;
					count   <= nxt.count;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_reports
		touch_report_t got;
		touch_report_t want;
		if (arst_n && done) begin
			got = {raw_count, peak_count, normalized, pressed, no_peak};
			if (touch_reports_due.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result raw=%h peak=%h norm=%0d pr=%b np=%b",
						got.raw, got.peak, got.norm, got.pressed, got.no_peak);
			end else begin
				want = touch_reports_due.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch exp raw=%h peak=%h norm=%0d pr=%b np=%b %s%h %s%h %s%0d %s%b %s%b",
							want.raw, want.peak, want.norm, want.pressed, want.no_peak,
							"got raw=", got.raw, "peak=", got.peak, "norm=", got.norm,
							"pr=", got.pressed, "np=", got.no_peak);
				end
			end
		end
	end

	task automatic add_cmd(input logic m, input logic [cptt_pkg::CH_W-1:0] ch,
			input logic [cptt_pkg::COUNT_W-1:0] cnt, input bit drain = 1'b0);
		touch_cmd_t c;
		c.mode    = m;
		c.channel = ch;
		c.count   = cnt;
		c.drain   = drain;
		touch_cmds_pending.push_back(c);
		if (m == cptt_pkg::MODE_MEAS && ch < NUM_CH && cnt > plan_peak[ch])
			plan_peak[ch] = cnt;
	endtask

	task automatic add_random_cmd(input bit drain);
		logic [cptt_pkg::CH_W-1:0]    ch;
		logic [cptt_pkg::COUNT_W-1:0] cnt;
		int                           pk;
		int                           kind;
		ch   = cptt_pkg::CH_W'($urandom_range(NUM_CH - 1));
		pk   = int'(plan_peak[ch]);
		kind = $urandom_range(99);
		if (kind < 20) begin
			add_cmd(cptt_pkg::MODE_READ, ch, cptt_pkg::COUNT_W'($urandom), drain);
		end else begin
			kind = $urandom_range(99);
			if (kind < 10)
				cnt = cptt_pkg::COUNT_W'($urandom);
			else if (kind < 22)
				cnt = (pk + 3000 > 65535) ? 16'hFFFF
					: cptt_pkg::COUNT_W'(pk + $urandom_range(1, 3000));
			else if (kind < 27)
				cnt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			else if (pk == 0)
				cnt = cptt_pkg::COUNT_W'($urandom_range(255));
			else
				cnt = cptt_pkg::COUNT_W'(pk - $urandom_range(pk / 2));
			add_cmd(cptt_pkg::MODE_MEAS, ch, cnt, drain);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_CH; i++) begin
			ch_latest[i] = '0;
			ch_peak[i]   = '0;
			plan_peak[i] = '0;
		end

		// zero peak on every channel, count ignored on read
		for (int i = 0; i < NUM_CH; i++)
			add_cmd(cptt_pkg::MODE_READ, cptt_pkg::CH_W'(i), 16'hFFFF);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd0, 16'h0000);
		add_cmd(cptt_pkg::MODE_READ, 2'd0, 16'h1234);
		// full scale peak, then drop to zero and around the 25% threshold
		add_cmd(cptt_pkg::MODE_MEAS, 2'd1, 16'hFFFF);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd1, 16'h0000);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd1, 16'd49152);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd1, 16'd49151);
		add_cmd(cptt_pkg::MODE_READ, 2'd1, 16'h0000);
		// peak of one: normalized at full 256
		add_cmd(cptt_pkg::MODE_MEAS, 2'd2, 16'd1);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd2, 16'd0);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd2, 16'd1, 1'b1);
		// peak raise
		add_cmd(cptt_pkg::MODE_MEAS, 2'd3, 16'd100);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd3, 16'd200);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd3, 16'd150);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd3, 16'd149);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd3, 16'd199);
		add_cmd(cptt_pkg::MODE_READ, 2'd3, 16'hAAAA);
		add_cmd(cptt_pkg::MODE_MEAS, 2'd0, 16'h5555);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			for (int i = 0; i < 200; i++)
				add_random_cmd(i % 64 == 0);
			while (touch_cmds_pending.size() != 0)
				@(posedge clk);
			send_idle_pct = (phase == 0) ? 67 : 0;
		end

		while (touch_cmds_pending.size() != 0 || start)
			@(posedge clk);
		while (touch_reports_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && touch_reports_due.size() == 0)
			$display("tb_capsense_peak_track_touch_unit OK");
		else
			$display("tb_capsense_peak_track_touch_unit NOT OK");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("tb_capsense_peak_track_touch_unit NOT OK");
		$finish;
	end

endmodule

### sim.f
src/cptt_pkg.sv
src/cptt_ctrl.sv
src/cptt_dp.sv
src/capsense_peak_track_touch_unit.sv
tb/tb_capsense_peak_track_touch_unit.sv
